// File: rtl/cbpd_pkg.sv
// Shared types, constants and address helpers for the console bus and port decoder.
package cbpd_pkg;

  localparam int RamBytes   = 8192;
  localparam int CartTop    = 'hC000;
  localparam int StoreDepth = CartTop + RamBytes;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int ClrW       = $clog2(StoreDepth + 1);

  localparam logic [15:0] LowWinLo = 16'h2000;
  localparam logic [15:0] LowWinHi = 16'h3FFF;
  localparam logic [15:0] MidWinLo = 16'h8000;
  localparam logic [15:0] MidWinHi = 16'h9FFF;
  localparam logic [15:0] CartEnd  = 16'hBFFF;

  localparam logic [7:0] PortSndLo = 8'h40;
  localparam logic [7:0] PortSndHi = 8'h7F;
  localparam logic [7:0] PortVdpLo = 8'h80;
  localparam logic [7:0] PortVdpHi = 8'hBF;
  localparam logic [7:0] PortCtlLo = 8'hC0;
  localparam logic [7:0] PortCtlHi = 8'hFF;

  localparam logic [7:0] ByteOnes  = 8'hFF;
  localparam logic [3:0] CtlUnused = 4'hF;
  localparam logic [15:0] CtlReset = 16'hFFFF;

  localparam logic CfgLowWin = 1'b0;
  localparam logic CfgMidWin = 1'b1;

  typedef enum logic [2:0] {
    CMD_MEM_RD   = 3'd0,
    CMD_MEM_WR   = 3'd1,
    CMD_PORT_RD  = 3'd2,
    CMD_PORT_WR  = 3'd3,
    CMD_CTL_UPD  = 3'd4,
    CMD_IMG_LOAD = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ROUTE_NONE = 2'd0,
    ROUTE_SND  = 2'd1,
    ROUTE_VREG = 2'd2,
    ROUTE_VMEM = 2'd3
  } route_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_e;

  typedef struct packed {
    logic             mem_we;
    logic             mem_re;
    logic [AddrW-1:0] mem_addr;
    logic [7:0]       rd_fixed;
    route_e           route;
    logic             nmi;
    logic             ctl_we;
    logic [15:0]      ctl_d;
    logic             pause_d;
  } dec_t;

  // Fold a work RAM address into its mirrored slot.
  function automatic logic [AddrW-1:0] ram_slot(input logic [15:0] addr);
    logic [15:0] v;
    v = {3'b000, addr[12:0]};
    if (v >= 16'(4 * RamBytes)) v = v - 16'(4 * RamBytes);
    if (v >= 16'(2 * RamBytes)) v = v - 16'(2 * RamBytes);
    if (v >= 16'(RamBytes))     v = v - 16'(RamBytes);
    return AddrW'(32'(CartTop) + 32'(v));
  endfunction

endpackage

// File: rtl/console_bus_and_port_decoder_unit.sv
// Top level of the console bus and port decoder: store, clear pass and result pipeline.
//
//   channel   dir   handshake                    payload
//   s_axis    in    s_axis_tvalid/s_axis_tready  tuser: command; tdata: see port list
//   m_axis    out   m_axis_tvalid/m_axis_tready  tdata: read_data, route, nmi_pulse
//   cfg       in    cfg_we_i                     cfg_idx_i, cfg_data_i
//
// One request per cycle while s_axis_tready is high; a result passes the store read,
// then the output register. The single store port sets the rate: one access per request.
// After reset a clearing pass zeroes the store, one byte per cycle, over all StoreDepth
// (57344) bytes, with s_axis_tready low. A stalled m_axis holds one result in the
// output register and one in the pending stage before s_axis_tready drops.
module console_bus_and_port_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] address, [23:16] data, [35:24] buttons, [36] pause_pressed, [39:37] zero
  input  logic [39:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [9:8] route, [10] nmi_pulse, [15:11] zero
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i
);

  cbpd_pkg::state_e state_q, state_d;
  logic [cbpd_pkg::ClrW-1:0] clr_cnt_q, clr_cnt_d;

  logic        low_en_q, mid_en_q;
  logic [15:0] ctl_q;
  logic        pause_q;

  logic        pend_q, pend_rd_q, pend_nmi_q;
  logic [7:0]  pend_rd_fixed_q;
  cbpd_pkg::route_e pend_route_q;

  logic        out_valid_q, out_nmi_q;
  logic [7:0]  out_rd_q;
  cbpd_pkg::route_e out_route_q;

  logic        accept, advance;
  cbpd_pkg::dec_t dec;

  logic                       ram_we, ram_re;
  logic [cbpd_pkg::AddrW-1:0] ram_addr;
  logic [7:0]                 ram_wdata, ram_rdata;

  assign advance       = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == cbpd_pkg::ST_RUN) && (!pend_q || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;

  cbpd_decode u_decode (
    .valid_i         (accept),
    .command_i       (s_axis_tuser),
    .address_i       (s_axis_tdata[15:0]),
    .buttons_i       (s_axis_tdata[35:24]),
    .pause_pressed_i (s_axis_tdata[36]),
    .ctl_q_i         (ctl_q),
    .pause_q_i       (pause_q),
    .low_en_i        (low_en_q),
    .mid_en_i        (mid_en_q),
    .dec_o           (dec)
  );

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    ram_we    = dec.mem_we;
    ram_re    = dec.mem_re;
    ram_addr  = dec.mem_addr;
    ram_wdata = s_axis_tdata[23:16];
    case (state_q)
      cbpd_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_re    = 1'b0;
        ram_addr  = clr_cnt_q[cbpd_pkg::AddrW-1:0];
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == cbpd_pkg::ClrW'(cbpd_pkg::StoreDepth - 1)) begin
          state_d = cbpd_pkg::ST_RUN;
        end
      end
      cbpd_pkg::ST_RUN: begin
      end
      default: begin
        state_d = cbpd_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cbpd_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  cbpd_ram #(
    .Width (8),
    .Depth (cbpd_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_en_q <= 1'b0;
      mid_en_q <= 1'b0;
      ctl_q    <= cbpd_pkg::CtlReset;
      pause_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == cbpd_pkg::CfgLowWin) begin
        low_en_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == cbpd_pkg::CfgMidWin) begin
        mid_en_q <= cfg_data_i;
      end
      if (dec.ctl_we) begin
        ctl_q   <= dec.ctl_d;
        pause_q <= dec.pause_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end else if (advance) begin
        pend_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_rd_q       <= dec.mem_re;
      pend_rd_fixed_q <= dec.rd_fixed;
      pend_route_q    <= dec.route;
      pend_nmi_q      <= dec.nmi;
    end
    if (advance) begin
      out_rd_q    <= pend_rd_q ? ram_rdata : pend_rd_fixed_q;
      out_route_q <= pend_route_q;
      out_nmi_q   <= pend_nmi_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_nmi_q, out_route_q, out_rd_q};

  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbpd_pkg::ST_CLEAR) |-> !s_axis_tready)
    else $error("request accepted during store clear");

  a_clear_owns_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbpd_pkg::ST_CLEAR) |-> (ram_we && !ram_re && ram_wdata == 8'h00))
    else $error("store port not held by clear pass");

  a_read_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && dec.mem_re) |=> (pend_q && pend_rd_q))
    else $error("memory read lost its pending slot");

  a_pend_not_lost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !advance) |=> pend_q)
    else $error("pending result dropped");

  a_nmi_clears_pause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && dec.nmi) |=> !pause_q)
    else $error("pause held after release pulse");

endmodule

// File: rtl/cbpd_ram.sv
// Generic single-port synchronous RAM with registered read.
module cbpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cbpd_decode.sv
// Command, memory map and port decoder for one bus request.
module cbpd_decode (
  input  logic             valid_i,
  input  logic [2:0]       command_i,
  input  logic [15:0]      address_i,
  input  logic [11:0]      buttons_i,
  input  logic             pause_pressed_i,
  input  logic [15:0]      ctl_q_i,
  input  logic             pause_q_i,
  input  logic             low_en_i,
  input  logic             mid_en_i,
  output cbpd_pkg::dec_t   dec_o
);

  logic [7:0] port;
  logic       is_cart;

  assign port    = address_i[7:0];
  assign is_cart = (address_i <= cbpd_pkg::CartEnd);

  always_comb begin
    dec_o          = '0;
    dec_o.route    = cbpd_pkg::ROUTE_NONE;
    dec_o.mem_addr = is_cart ? cbpd_pkg::AddrW'(address_i)
                             : cbpd_pkg::ram_slot(address_i);
    dec_o.ctl_d    = ctl_q_i;
    dec_o.pause_d  = pause_q_i;
    case (cbpd_pkg::cmd_e'(command_i))
      cbpd_pkg::CMD_MEM_RD: begin
        dec_o.mem_re = valid_i;
      end
      cbpd_pkg::CMD_MEM_WR: begin
        if (!is_cart) begin
          dec_o.mem_we = valid_i;
        end else if (address_i inside {[cbpd_pkg::LowWinLo:cbpd_pkg::LowWinHi]}) begin
          dec_o.mem_we = valid_i && low_en_i;
        end else if (address_i inside {[cbpd_pkg::MidWinLo:cbpd_pkg::MidWinHi]}) begin
          dec_o.mem_we = valid_i && mid_en_i;
        end
      end
      cbpd_pkg::CMD_PORT_RD: begin
        if (port inside {[cbpd_pkg::PortVdpLo:cbpd_pkg::PortVdpHi]}) begin
          dec_o.rd_fixed = cbpd_pkg::ByteOnes;
          dec_o.route    = port[0] ? cbpd_pkg::ROUTE_VREG : cbpd_pkg::ROUTE_VMEM;
        end else if (port inside {[cbpd_pkg::PortCtlLo:cbpd_pkg::PortCtlHi]}) begin
          dec_o.rd_fixed = port[0] ? ctl_q_i[15:8] : ctl_q_i[7:0];
        end else begin
          dec_o.rd_fixed = cbpd_pkg::ByteOnes;
        end
      end
      cbpd_pkg::CMD_PORT_WR: begin
        if (port inside {[cbpd_pkg::PortSndLo:cbpd_pkg::PortSndHi]}) begin
          dec_o.route = cbpd_pkg::ROUTE_SND;
        end else if (port inside {[cbpd_pkg::PortVdpLo:cbpd_pkg::PortVdpHi]}) begin
          dec_o.route = port[0] ? cbpd_pkg::ROUTE_VREG : cbpd_pkg::ROUTE_VMEM;
        end
      end
      cbpd_pkg::CMD_CTL_UPD: begin
        dec_o.ctl_we  = valid_i;
        dec_o.ctl_d   = {cbpd_pkg::CtlUnused, ~buttons_i};
        dec_o.pause_d = pause_pressed_i;
        dec_o.nmi     = !pause_pressed_i && pause_q_i;
      end
      cbpd_pkg::CMD_IMG_LOAD: begin
        dec_o.mem_we = valid_i && is_cart;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: bench/tb_console_bus_and_port_decoder_unit.sv
// Self-checking bench for the console bus and port decoder: predicts every bus reply.
`timescale 1ns / 1ps

module tb_console_bus_and_port_decoder_unit;
  import cbpd_pkg::*;

  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam int CycleLimit = 1_000_000;
  localparam int PhaseItems = 450;

  typedef struct packed {
    logic [7:0] rd;
    route_e     route;
    logic       nmi;
  } bus_reply_t;

  class bus_map_scoreboard;
    bit [7:0]   image [StoreDepth];
    bit [15:0]  pad_bits = CtlReset;
    bit         pause_latched = 1'b0;
    bit         low_win_en = 1'b0;
    bit         mid_win_en = 1'b0;
    bus_reply_t pending_replies[$];
    int         errors = 0;
    int         reply_count = 0;

    function int mirror_slot(input logic [15:0] addr);
      return CartTop + (int'(addr & 16'h1FFF) % RamBytes);
    endfunction

    function void set_reg(input logic idx, input logic val);
      if (idx == CfgLowWin) low_win_en = val;
      else mid_win_en = val;
    endfunction

    function void note_request(input logic [2:0] cmd, input logic [15:0] addr,
                               input logic [7:0] din, input logic [11:0] btn,
                               input logic pause);
      bus_reply_t r;
      logic [7:0] port;
      r.rd = 8'h00;
      r.route = ROUTE_NONE;
      r.nmi = 1'b0;
      port = addr[7:0];
      case (cmd)
        CMD_MEM_RD: begin
          r.rd = (addr < CartTop) ? image[int'(addr)] : image[mirror_slot(addr)];
        end
        CMD_MEM_WR: begin
          if (addr >= LowWinLo && addr <= LowWinHi) begin
            if (low_win_en) image[int'(addr)] = din;
          end else if (addr >= MidWinLo && addr <= MidWinHi) begin
            if (mid_win_en) image[int'(addr)] = din;
          end else if (addr >= CartTop) begin
            image[mirror_slot(addr)] = din;
          end
        end
        CMD_PORT_RD: begin
          if (port >= PortVdpLo && port <= PortVdpHi) begin
            r.rd = ByteOnes;
            r.route = port[0] ? ROUTE_VREG : ROUTE_VMEM;
          end else if (port >= PortCtlLo) begin
            r.rd = port[0] ? pad_bits[15:8] : pad_bits[7:0];
          end else begin
            r.rd = ByteOnes;
          end
        end
        CMD_PORT_WR: begin
          if (port >= PortSndLo && port <= PortSndHi) r.route = ROUTE_SND;
          else if (port >= PortVdpLo && port <= PortVdpHi)
            r.route = port[0] ? ROUTE_VREG : ROUTE_VMEM;
        end
        CMD_CTL_UPD: begin
          pad_bits = {CtlUnused, ~btn};
          if (pause) begin
            pause_latched = 1'b1;
          end else begin
            r.nmi = pause_latched;
            pause_latched = 1'b0;
          end
        end
        CMD_IMG_LOAD: begin
          if (addr < CartTop) image[int'(addr)] = din;
        end
        default: ;
      endcase
      pending_replies = {pending_replies, r};
    endfunction

    function void check_result(input logic [15:0] word);
      bus_reply_t want;
      reply_count++;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("reply %0d arrived with none pending: tdata %h",
                                   reply_count, word);
        return;
      end
      want = pending_replies.pop_front();
      if (word[7:0] !== want.rd || word[9:8] !== want.route || word[10] !== want.nmi) begin
        errors++;
        if (errors <= 10)
          $display("reply %0d mismatch: read_data %h/%h route %0d/%0d nmi %b/%b (exp/got)",
                   reply_count, want.rd, word[7:0], want.route, word[9:8],
                   want.nmi, word[10]);
      end
    endfunction

    function int waiting();
      return pending_replies.size();
    endfunction

    function bit clean();
      return errors == 0 && pending_replies.size() == 0;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic        cfg_data_i;

  bus_map_scoreboard sb;
  bit steady = 1'b0;
  int sink_left = 0;
  int cycles = 0;

  console_bus_and_port_decoder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] hot_address();
    logic [15:0] base;
    case ($urandom_range(0, 12))
      0: base = 16'h0000;
      1: base = 16'h1FF8;
      2: base = 16'h2000;
      3: base = 16'h3FF8;
      4: base = 16'h4000;
      5: base = 16'h8000;
      6: base = 16'h9FF8;
      7: base = 16'hA000;
      8: base = 16'hBFF8;
      9: base = 16'hC000;
      10: base = 16'hDFF8;
      11: base = 16'hE000;
      default: base = 16'hFFF8;
    endcase
    return base + 16'($urandom_range(0, 7));
  endfunction

  always @(posedge clk_i) begin
    if (sink_left > 0) begin
      sink_left--;
    end else if (steady || $urandom_range(0, 2) != 0) begin
      m_axis_tready <= 1'b1;
      sink_left = $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b0;
      sink_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic issue(input logic [2:0] cmd, input logic [15:0] addr,
                       input logic [7:0] din, input logic [11:0] btn, input logic pause);
    int gap;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, pause, btn, din, addr};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, addr, din, btn, pause);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.waiting() != 0);
  endtask

  task automatic write_regs(input logic low_en, input logic mid_en);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgLowWin;
    cfg_data_i <= low_en;
    @(posedge clk_i);
    sb.set_reg(CfgLowWin, low_en);
    cfg_idx_i  <= CfgMidWin;
    cfg_data_i <= mid_en;
    @(posedge clk_i);
    sb.set_reg(CfgMidWin, mid_en);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_request();
    logic [2:0]  cmd;
    logic [15:0] addr;
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) cmd = CMD_MEM_RD;
    else if (r < 40) cmd = CMD_MEM_WR;
    else if (r < 54) cmd = CMD_PORT_RD;
    else if (r < 64) cmd = CMD_PORT_WR;
    else if (r < 76) cmd = CMD_CTL_UPD;
    else if (r < 94) cmd = CMD_IMG_LOAD;
    else if (r < 97) cmd = CmdSpare6;
    else cmd = CmdSpare7;
    if (cmd == CMD_PORT_RD || cmd == CMD_PORT_WR || $urandom_range(0, 9) < 3)
      addr = 16'($urandom_range(0, 65535));
    else
      addr = hot_address();
    issue(cmd, addr, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
          1'($urandom_range(0, 1)));
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgLowWin;
    cfg_data_i    = 1'b0;
    rst_ni        = 1'b0;
    sb = new;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(CMD_MEM_RD,   16'h0000, 8'h00, 12'h000, 1'b0);
    issue(CMD_IMG_LOAD, 16'h0000, 8'hA5, 12'h000, 1'b0);
    issue(CMD_IMG_LOAD, 16'hBFFF, 8'h5A, 12'h000, 1'b0);
    issue(CMD_IMG_LOAD, 16'hC000, 8'h77, 12'h000, 1'b0);
    issue(CMD_MEM_RD,   16'hBFFF, 8'h00, 12'h000, 1'b0);
    issue(CMD_MEM_WR,   16'hFFFF, 8'hFF, 12'h000, 1'b0);
    issue(CMD_MEM_RD,   16'hDFFF, 8'h00, 12'h000, 1'b0);
    issue(CMD_MEM_WR,   16'hE000, 8'h3C, 12'h000, 1'b0);
    issue(CMD_MEM_RD,   16'hC000, 8'h00, 12'h000, 1'b0);
    issue(CMD_MEM_WR,   16'h2000, 8'h11, 12'h000, 1'b0);
    issue(CMD_MEM_WR,   16'h0000, 8'h99, 12'h000, 1'b0);
    issue(CMD_MEM_RD,   16'h0000, 8'h00, 12'h000, 1'b0);
    issue(CMD_PORT_RD,  16'h00BE, 8'h00, 12'h000, 1'b0);
    issue(CMD_PORT_RD,  16'hFF81, 8'h00, 12'h000, 1'b0);
    issue(CMD_PORT_RD,  16'h007F, 8'h00, 12'h000, 1'b0);
    issue(CMD_PORT_WR,  16'h0040, 8'h9F, 12'h000, 1'b0);
    issue(CMD_PORT_WR,  16'hFFBF, 8'h81, 12'h000, 1'b0);
    issue(CMD_PORT_WR,  16'h0080, 8'h00, 12'h000, 1'b0);
    issue(CMD_PORT_WR,  16'h00C0, 8'hFF, 12'h000, 1'b0);
    issue(CMD_CTL_UPD,  16'h0000, 8'h00, 12'hFFF, 1'b1);
    issue(CMD_PORT_RD,  16'h12DC, 8'h00, 12'h000, 1'b0);
    issue(CMD_PORT_RD,  16'h00FF, 8'h00, 12'h000, 1'b0);
    issue(CMD_CTL_UPD,  16'h0000, 8'h00, 12'h000, 1'b0);
    issue(CMD_CTL_UPD,  16'h0000, 8'h00, 12'hA5A, 1'b0);
    issue(CmdSpare6,    16'hFFFF, 8'hFF, 12'hFFF, 1'b1);
    issue(CmdSpare7,    16'hFFFF, 8'hFF, 12'hFFF, 1'b1);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_regs(1'b1, 1'b1);
        1: write_regs(1'b1, 1'b0);
        2: write_regs(1'b0, 1'b1);
        default: write_regs(1'b0, 1'b0);
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        steady = (n < 60);
        if (n == 200) settle();
        random_request();
      end
      steady = 1'b0;
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (sb.clean()) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
